@@ sv/rbd_pkg.sv @@
// shared types and constants for the ring buffer deque
`default_nettype none
package rbd_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = AW + 1;

    // request kinds
    localparam logic [1:0] REQ_PUSH_TAIL = 2'd0;
    localparam logic [1:0] REQ_POP_HEAD  = 2'd1;
    localparam logic [1:0] REQ_POP_TAIL  = 2'd2;
    localparam logic [1:0] REQ_PEEK_HEAD = 2'd3;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [DATA_WIDTH-1:0] push_data;
    } t_req;

    typedef struct packed {
        logic                  ok;
        logic [DATA_WIDTH-1:0] read_data;
        logic [CW-1:0]         fill_count;
        logic                  empty_flag;
    } t_rsp;

endpackage
`default_nettype wire

@@ sv/rbd_slot_ram.sv @@
// slot storage: one write port, one read port with registered read data
`default_nettype none
module rbd_slot_ram
    import rbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/ring_buffer_deque_unit.sv @@
// ring buffer deque top level: pointer control, slot memory and result register
// a request's result passes the pending register and the slot memory read, then the result register
// a new request is stalled while the last one waits for slot memory read data or a stalled result is held
// reset: buffer empty, head and tail at slot 0, capacity at the full depth
// slot memory contents are not cleared by reset; a capacity write empties the buffer
`default_nettype none
module ring_buffer_deque_unit
    import rbd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request channel
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire t_req          i_in_data,
    // result channel
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output t_rsp               o_out_data,
    // capacity register write
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [CW-1:0] i_cfg_data
);

    localparam logic [CW-1:0] CAP_MAX = CW'(DEPTH);

    logic [CW-1:0] r_cap,   n_cap;
    logic [AW-1:0] r_head,  n_head;
    logic [AW-1:0] r_tail,  n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          r_pend;
    logic          r_pend_ok;
    logic          r_pend_rd;
    logic [CW-1:0] r_pend_count;

    logic          r_out_valid;
    t_rsp          r_out;

    logic          in_acc;
    logic          cfg_acc;
    logic          ok;
    logic          rd;
    logic          we;
    logic [AW-1:0] raddr;
    logic [CW-1:0] head_inc;
    logic [CW-1:0] tail_inc;
    logic [AW-1:0] head_fwd;
    logic [AW-1:0] tail_fwd;
    logic [AW-1:0] tail_back;
    logic [CW-1:0] cap_m1;
    logic [CW-1:0] cfg_cap;
    logic [DATA_WIDTH-1:0] ram_q;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign o_in_stall  = r_pend || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;

    // pointer steps wrapping at the configured capacity
    assign head_inc  = {1'b0, r_head} + CW'(1);
    assign tail_inc  = {1'b0, r_tail} + CW'(1);
    assign head_fwd  = (head_inc >= r_cap) ? '0 : head_inc[AW-1:0];
    assign tail_fwd  = (tail_inc >= r_cap) ? '0 : tail_inc[AW-1:0];
    assign cap_m1    = r_cap - CW'(1);
    assign tail_back = (r_tail == '0) ? cap_m1[AW-1:0] : r_tail - AW'(1);

    // capacity clamp on write
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = CW'(1);
        end else if (i_cfg_data > CAP_MAX) begin
            cfg_cap = CAP_MAX;
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    // request decode and next pointer state
    always_comb begin
        n_cap   = r_cap;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        ok      = 1'b0;
        rd      = 1'b0;
        we      = 1'b0;
        raddr   = r_head;
        if (in_acc) begin
            case (i_in_data.req_type)
                REQ_PUSH_TAIL: begin
                    if (r_count < r_cap) begin
                        ok      = 1'b1;
                        we      = 1'b1;
                        n_tail  = tail_fwd;
                        n_count = r_count + CW'(1);
                    end
                end
                REQ_POP_HEAD: begin
                    if (r_count != '0) begin
                        ok      = 1'b1;
                        rd      = 1'b1;
                        n_head  = head_fwd;
                        n_count = r_count - CW'(1);
                    end
                end
                REQ_POP_TAIL: begin
                    if (r_count != '0) begin
                        ok      = 1'b1;
                        rd      = 1'b1;
                        raddr   = tail_back;
                        n_tail  = tail_back;
                        n_count = r_count - CW'(1);
                    end
                end
                REQ_PEEK_HEAD: begin
                    if (r_count != '0) begin
                        ok = 1'b1;
                        rd = 1'b1;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
        if (cfg_acc) begin
            n_cap   = cfg_cap;
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    // slot memory
    rbd_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (i_in_data.push_data),
        .i_re    (rd),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // pointer and capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_MAX;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_cap   <= n_cap;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // request waiting for memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend_ok    <= ok;
            r_pend_rd    <= rd;
            r_pend_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out.ok         <= r_pend_ok;
            r_out.read_data  <= r_pend_rd ? ram_q : '0;
            r_out.fill_count <= r_pend_count;
            r_out.empty_flag <= (r_pend_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
